@@ hdl/rcq_pkg.sv @@
// Shared types and constants for the range cue qualifier.
// Used by rcq_step and range_cue_qualifier; depends on nothing else.
package rcq_pkg;

	localparam int RANGE_W      = 16;
	localparam int MARGIN_W     = 8;
	localparam int TICK_W       = 10;
	localparam int PHASE_W      = 9;
	localparam int TTI_W        = 15;
	localparam int FT_W         = 16;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int DT_LIMIT     = 256;
	localparam int FILTER_TICKS = 256;
	localparam int FILTER_SHIFT = 8;
	localparam int FLASH_BIT    = 8;
	// Gain width holds FILTER_TICKS itself.
	localparam int GAIN_W       = $clog2(FILTER_TICKS + 1);
	localparam int DIFF_W       = RANGE_W + 1;
	localparam int PROD_W       = DIFF_W + GAIN_W + 1;
	// Window bounds are compared signed with headroom on both ends.
	localparam int BOUND_W      = RANGE_W + 2;

	localparam logic [MARGIN_W-1:0] ENTRY_LOW_RST  = MARGIN_W'(10);
	localparam logic [MARGIN_W-1:0] ENTRY_HIGH_RST = MARGIN_W'(20);
	localparam logic [MARGIN_W-1:0] EXIT_LOW_RST   = MARGIN_W'(10);
	localparam logic [MARGIN_W-1:0] EXIT_HIGH_RST  = MARGIN_W'(20);
	localparam logic [TICK_W-1:0]   HOLD_TIME_RST  = TICK_W'(512);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTRY_LOW  = 3'd0,
		REG_ENTRY_HIGH = 3'd1,
		REG_EXIT_LOW   = 3'd2,
		REG_EXIT_HIGH  = 3'd3,
		REG_HOLD_TIME  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] entry_low_margin;
		logic [MARGIN_W-1:0] entry_high_margin;
		logic [MARGIN_W-1:0] exit_low_margin;
		logic [MARGIN_W-1:0] exit_high_margin;
		logic [TICK_W-1:0]   hold_time;
	} cfg_t;

	typedef struct packed {
		logic                    mode_is_prelaunch;
		logic                    range_valid;
		logic [RANGE_W-1:0]      raw_range;
		logic                    shoot_cue;
		logic [RANGE_W-1:0]      min_range;
		logic [RANGE_W-1:0]      intercept_range;
		logic signed [FT_W-1:0]  flight_time;
		logic [TICK_W-1:0]       dt_ticks;
	} item_t;

	typedef struct packed {
		logic [RANGE_W-1:0] filtered_value;
		logic               filter_loaded;
		logic               indication_on;
		logic [TICK_W-1:0]  hold_left;
		logic [PHASE_W-1:0] blink_phase;
	} state_t;

	typedef struct packed {
		logic [RANGE_W-1:0] smoothed_range;
		logic               shoot_active;
		logic               shoot_flash;
		logic [TTI_W-1:0]   time_to_impact;
		logic               tracking;
	} result_t;

endpackage

@@ hdl/rcq_step.sv @@
// Next-state and result logic for one update of the range cue qualifier.
// Purely combinational; uses the types and constants of rcq_pkg.
module rcq_step (
	input  rcq_pkg::cfg_t    cfg,
	input  rcq_pkg::item_t   item,
	input  rcq_pkg::state_t  state,
	output rcq_pkg::state_t  next_state,
	output rcq_pkg::result_t result
);
	import rcq_pkg::*;

	logic                       cleared;
	logic [TICK_W-1:0]          dt_clamp;
	logic [GAIN_W-1:0]          gain;
	logic [PHASE_W-1:0]         phase_nxt;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   step;
	logic [RANGE_W-1:0]         filt_nxt;
	logic [TICK_W-1:0]          hold_dec;
	logic signed [BOUND_W-1:0]  r_s;
	logic signed [BOUND_W-1:0]  enter_lo;
	logic signed [BOUND_W-1:0]  enter_hi;
	logic signed [BOUND_W-1:0]  leave_lo;
	logic signed [BOUND_W-1:0]  leave_hi;
	logic                       entry;
	logic                       leave;
	logic                       on_nxt;
	logic [TICK_W-1:0]          hold_nxt;

	always_comb begin
		cleared = !item.mode_is_prelaunch || !item.range_valid;

		if (item.dt_ticks > TICK_W'(DT_LIMIT)) begin
			dt_clamp = TICK_W'(DT_LIMIT);
		end else begin
			dt_clamp = item.dt_ticks;
		end
		if (dt_clamp > TICK_W'(FILTER_TICKS)) begin
			gain = GAIN_W'(FILTER_TICKS);
		end else begin
			gain = GAIN_W'(dt_clamp);
		end

		phase_nxt = state.blink_phase + PHASE_W'(dt_clamp);

		// The arithmetic shift floors, which matches the rounding toward minus infinity.
		diff = $signed({1'b0, item.raw_range}) - $signed({1'b0, state.filtered_value});
		prod = PROD_W'(diff) * $signed({{(PROD_W-GAIN_W){1'b0}}, gain});
		step = prod >>> FILTER_SHIFT;
		if (state.filter_loaded) begin
			filt_nxt = state.filtered_value + step[RANGE_W-1:0];
		end else begin
			filt_nxt = item.raw_range;
		end

		if (state.hold_left > dt_clamp) begin
			hold_dec = state.hold_left - dt_clamp;
		end else begin
			hold_dec = '0;
		end

		r_s      = $signed({2'b00, item.raw_range});
		enter_lo = $signed({2'b00, item.min_range})
			+ $signed({{(BOUND_W-MARGIN_W){1'b0}}, cfg.entry_low_margin});
		enter_hi = $signed({2'b00, item.intercept_range})
			- $signed({{(BOUND_W-MARGIN_W){1'b0}}, cfg.entry_high_margin});
		leave_lo = $signed({2'b00, item.min_range})
			- $signed({{(BOUND_W-MARGIN_W){1'b0}}, cfg.exit_low_margin});
		leave_hi = $signed({2'b00, item.intercept_range})
			+ $signed({{(BOUND_W-MARGIN_W){1'b0}}, cfg.exit_high_margin});

		entry = item.shoot_cue && (r_s > enter_lo) && (r_s < enter_hi);
		leave = (r_s <= leave_lo) || (r_s > leave_hi);

		on_nxt   = state.indication_on;
		hold_nxt = state.indication_on ? hold_dec : state.hold_left;
		if (!state.indication_on && entry) begin
			on_nxt   = 1'b1;
			hold_nxt = cfg.hold_time;
		end else if (state.indication_on && leave && hold_dec == '0) begin
			on_nxt = 1'b0;
		end

		if (cleared) begin
			next_state = '0;
			result     = '0;
		end else begin
			next_state.filtered_value = filt_nxt;
			next_state.filter_loaded  = 1'b1;
			next_state.indication_on  = on_nxt;
			next_state.hold_left      = hold_nxt;
			next_state.blink_phase    = phase_nxt;

			result.smoothed_range = filt_nxt;
			result.shoot_active   = on_nxt;
			result.shoot_flash    = on_nxt && !phase_nxt[FLASH_BIT];
			result.time_to_impact = item.flight_time[FT_W-1] ? '0
				: item.flight_time[TTI_W-1:0];
			result.tracking       = 1'b1;
		end
	end

endmodule

@@ hdl/range_cue_qualifier.sv @@
// Range cue qualifier: input stage, then result register; one update per cycle
// while the output is not stalled; the filter and cue state close their loop
// through a single combinational step between the input stage and result register.
// Input stall rises only while a result waits and the output is stalled.
// arst_n clears the pipeline, all filter and cue state, and loads register defaults.
// Depends on rcq_pkg and rcq_step.
module range_cue_qualifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rcq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcq_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode_is_prelaunch,
	input  logic                                range_valid,
	input  logic [rcq_pkg::RANGE_W-1:0]         raw_range,
	input  logic                                shoot_cue,
	input  logic [rcq_pkg::RANGE_W-1:0]         min_range,
	input  logic [rcq_pkg::RANGE_W-1:0]         intercept_range,
	input  logic signed [rcq_pkg::FT_W-1:0]     flight_time,
	input  logic [rcq_pkg::TICK_W-1:0]          dt_ticks,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rcq_pkg::RANGE_W-1:0]         smoothed_range,
	output logic                                shoot_active,
	output logic                                shoot_flash,
	output logic [rcq_pkg::TTI_W-1:0]           time_to_impact,
	output logic                                tracking
);
	import rcq_pkg::*;

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    advance;

	assign item_in.mode_is_prelaunch = mode_is_prelaunch;
	assign item_in.range_valid       = range_valid;
	assign item_in.raw_range         = raw_range;
	assign item_in.shoot_cue         = shoot_cue;
	assign item_in.min_range         = min_range;
	assign item_in.intercept_range   = intercept_range;
	assign item_in.flight_time       = flight_time;
	assign item_in.dt_ticks          = dt_ticks;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_low_margin  <= ENTRY_LOW_RST;
			cfg_q.entry_high_margin <= ENTRY_HIGH_RST;
			cfg_q.exit_low_margin   <= EXIT_LOW_RST;
			cfg_q.exit_high_margin  <= EXIT_HIGH_RST;
			cfg_q.hold_time         <= HOLD_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_LOW:  cfg_q.entry_low_margin  <= cfg_data[MARGIN_W-1:0];
				REG_ENTRY_HIGH: cfg_q.entry_high_margin <= cfg_data[MARGIN_W-1:0];
				REG_EXIT_LOW:   cfg_q.exit_low_margin   <= cfg_data[MARGIN_W-1:0];
				REG_EXIT_HIGH:  cfg_q.exit_high_margin  <= cfg_data[MARGIN_W-1:0];
				REG_HOLD_TIME:  cfg_q.hold_time         <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	rcq_step u_step (
		.cfg        (cfg_q),
		.item       (item_s1),
		.state      (state_q),
		.next_state (state_nxt),
		.result     (res_nxt)
	);

	// State moves together with the result so the next update sees it at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_range = res_q.smoothed_range;
	assign shoot_active   = res_q.shoot_active;
	assign shoot_flash    = res_q.shoot_flash;
	assign time_to_impact = res_q.time_to_impact;
	assign tracking       = res_q.tracking;

`ifndef SYNTH
	// The input side is held back only by a result that cannot leave.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_flash_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!shoot_flash || shoot_active))
		else $error("flash shown while indication is off");

	// A cleared update leaves no cue and no filter history behind.
	a_cleared_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tracking) |-> (!shoot_active && !state_q.filter_loaded
		&& smoothed_range == '0))
		else $error("cleared update kept state");

	a_track_loads_filter: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (state_q.filter_loaded == tracking))
		else $error("filter load flag disagrees with tracking");
`endif

endmodule

@@ sim/range_cue_qualifier_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for range_cue_qualifier: directed and random updates,
// a local predictor of the filter and shoot cue, and random gaps on both sides.
// Depends on rcq_pkg and the range_cue_qualifier RTL.
module range_cue_qualifier_test;
	import rcq_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int SEGMENTS    = 6;
	localparam int SEG_UPDATES = 125;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	reg_idx_t              cfg_index = REG_ENTRY_LOW;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic  in_valid = 1'b0;
	logic  in_stall;
	item_t in_item = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [RANGE_W-1:0] smoothed_range;
	logic               shoot_active;
	logic               shoot_flash;
	logic [TTI_W-1:0]   time_to_impact;
	logic               tracking;

	item_t   pending_updates[$];
	result_t predicted_outputs[$];
	result_t want;
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	int      send_gap_pct = 36;
	int      recv_stall_pct = 67;

	// Predictor copy of the thresholds and the qualifier state.
	cfg_t               qual_cfg;
	logic [RANGE_W-1:0] flt_range;
	logic               flt_loaded;
	logic               cue_on;
	logic [TICK_W-1:0]  hold_ticks;
	logic [PHASE_W-1:0] blink_ticks;

	// Random target track: a window and a range that wanders around it.
	int win_lo;
	int win_hi;
	int track_at;
	int track_left = 0;

	range_cue_qualifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode_is_prelaunch(in_item.mode_is_prelaunch),
		.range_valid(in_item.range_valid),
		.raw_range(in_item.raw_range),
		.shoot_cue(in_item.shoot_cue),
		.min_range(in_item.min_range),
		.intercept_range(in_item.intercept_range),
		.flight_time(in_item.flight_time),
		.dt_ticks(in_item.dt_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.smoothed_range(smoothed_range),
		.shoot_active(shoot_active),
		.shoot_flash(shoot_flash),
		.time_to_impact(time_to_impact),
		.tracking(tracking)
	);

	always #6 clk = ~clk;

	function automatic void clear_track_state();
		flt_range = '0;
		flt_loaded = 1'b0;
		cue_on = 1'b0;
		hold_ticks = '0;
		blink_ticks = '0;
	endfunction

	function automatic result_t predict_update(item_t it);
		result_t res;
		longint r, lo, hi, step;
		int unsigned dt;
		logic enter, leave;
		res = '0;
		if (!it.mode_is_prelaunch || !it.range_valid) begin
			clear_track_state();
			return res;
		end
		dt = (it.dt_ticks > DT_LIMIT) ? DT_LIMIT : it.dt_ticks;
		blink_ticks = blink_ticks + PHASE_W'(dt);
		r = longint'(it.raw_range);
		lo = longint'(it.min_range);
		hi = longint'(it.intercept_range);
		if (!flt_loaded) begin
			flt_range = it.raw_range;
			flt_loaded = 1'b1;
		end else begin
			// The clamped step never exceeds the filter time constant, so the gain is dt.
			step = ((r - longint'(flt_range)) * longint'(dt)) >>> FILTER_SHIFT;
			flt_range = RANGE_W'(longint'(flt_range) + step);
		end
		if (cue_on)
			hold_ticks = (hold_ticks > dt) ? hold_ticks - TICK_W'(dt) : '0;
		enter = it.shoot_cue && r > lo + longint'(qual_cfg.entry_low_margin) &&
			r < hi - longint'(qual_cfg.entry_high_margin);
		leave = r <= lo - longint'(qual_cfg.exit_low_margin) ||
			r > hi + longint'(qual_cfg.exit_high_margin);
		if (!cue_on && enter) begin
			cue_on = 1'b1;
			hold_ticks = qual_cfg.hold_time;
		end else if (cue_on && leave && hold_ticks == '0) begin
			cue_on = 1'b0;
		end
		res.smoothed_range = flt_range;
		res.shoot_active = cue_on;
		res.shoot_flash = cue_on && !blink_ticks[FLASH_BIT];
		res.time_to_impact = it.flight_time[FT_W-1] ? '0 : it.flight_time[TTI_W-1:0];
		res.tracking = 1'b1;
		return res;
	endfunction

	function automatic item_t make_update(int mode, int ok, int raw, int cue, int lo, int hi,
			int ft, int dt);
		item_t it;
		it.mode_is_prelaunch = mode != 0;
		it.range_valid = ok != 0;
		it.raw_range = RANGE_W'(raw);
		it.shoot_cue = cue != 0;
		it.min_range = RANGE_W'(lo);
		it.intercept_range = RANGE_W'(hi);
		it.flight_time = FT_W'(ft);
		it.dt_ticks = TICK_W'(dt);
		return it;
	endfunction

	function automatic item_t random_update();
		item_t it;
		logic [95:0] noise;
		int unsigned pick;
		pick = $urandom_range(99);
		if (track_left == 0) begin
			case ($urandom_range(3))
				0: win_lo = int'($urandom_range(300));
				1: win_lo = int'($urandom_range(65535, 62000));
				default: win_lo = int'($urandom_range(60000));
			endcase
			win_hi = win_lo + int'($urandom_range(3000));
			if (win_hi > 65535)
				win_hi = 65535;
			track_at = win_lo + int'($urandom_range(win_hi - win_lo));
			track_left = int'($urandom_range(60, 20));
		end
		track_left--;
		if ($urandom_range(9) == 0)
			track_at = win_lo - 600 + int'($urandom_range(win_hi - win_lo + 1200));
		else
			track_at = track_at + int'($urandom_range(400)) - 200;
		if (track_at < 0)
			track_at = 0;
		if (track_at > 65535)
			track_at = 65535;
		it = make_update(1, 1, track_at, int'($urandom_range(9) != 0), win_lo, win_hi,
			int'($urandom), (pick < 75) ? int'($urandom_range(48)) : int'($urandom));
		if (pick < 6) begin
			noise = {$urandom, $urandom, $urandom};
			it = noise[$bits(item_t)-1:0];
		end else if (pick < 10) begin
			if ($urandom_range(1) == 0)
				it.mode_is_prelaunch = 1'b0;
			else
				it.range_valid = 1'b0;
		end
		return it;
	endfunction

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_updates.size() != 0 || in_valid || predicted_outputs.size() != 0);
	endtask

	task automatic load_thresholds(cfg_t th);
		reg_idx_t              order[5];
		logic [CFG_DATA_W-1:0] vals[5];
		order = '{REG_ENTRY_LOW, REG_ENTRY_HIGH, REG_EXIT_LOW, REG_EXIT_HIGH, REG_HOLD_TIME};
		vals = '{CFG_DATA_W'(th.entry_low_margin), CFG_DATA_W'(th.entry_high_margin),
			CFG_DATA_W'(th.exit_low_margin), CFG_DATA_W'(th.exit_high_margin),
			CFG_DATA_W'(th.hold_time)};
		@(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		qual_cfg = th;
	endtask

	// Driver: the expectation is formed at the edge where the update transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predicted_outputs.push_back(predict_update(in_item));
			if (!in_valid || !in_stall) begin
				if (pending_updates.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					in_item <= pending_updates.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					$display("%0t: result transfer with none expected, range %0d tracking %0d",
						$time, smoothed_range, tracking);
					mismatch_count++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("smoothed_range", want.smoothed_range, smoothed_range);
					check_field("shoot_active", want.shoot_active, shoot_active);
					check_field("shoot_flash", want.shoot_flash, shoot_flash);
					check_field("time_to_impact", want.time_to_impact, time_to_impact);
					check_field("tracking", want.tracking, tracking);
				end
			end
			out_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL range_cue_qualifier");
				$finish;
			end
		end
	end

	initial begin
		cfg_t th;
		qual_cfg = '{ENTRY_LOW_RST, ENTRY_HIGH_RST, EXIT_LOW_RST, EXIT_HIGH_RST, HOLD_TIME_RST};
		clear_track_state();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed updates under the reset thresholds.
		pending_updates.push_back(make_update(1, 1, 1000, 1, 500, 2000, 100, 0));
		pending_updates.push_back(make_update(1, 1, 65535, 1, 500, 2000, 32767, 1023));
		pending_updates.push_back(make_update(1, 1, 0, 1, 500, 2000, -1, 256));
		pending_updates.push_back(make_update(1, 1, 1000, 1, 500, 2000, 0, 100));
		pending_updates.push_back(make_update(1, 1, 0, 0, 500, 2000, -32768, 1));
		pending_updates.push_back(make_update(1, 1, 0, 0, 500, 2000, 5, 255));
		pending_updates.push_back(make_update(1, 1, 3000, 0, 500, 2000, 5, 200));
		pending_updates.push_back(make_update(1, 1, 3000, 0, 500, 2000, 5, 256));
		pending_updates.push_back(make_update(0, 1, 1234, 1, 500, 2000, 7, 10));
		pending_updates.push_back(make_update(1, 1, 300, 1, 0, 65535, 7, 10));
		pending_updates.push_back(make_update(1, 0, 300, 1, 0, 65535, 7, 10));
		pending_updates.push_back(make_update(1, 1, 5, 1, 0, 65535, 1, 3));
		pending_updates.push_back(make_update(1, 1, 0, 0, 5, 10, 1, 256));
		pending_updates.push_back(make_update(1, 1, 65535, 1, 65530, 65535, 1, 256));
		pending_updates.push_back(make_update(1, 1, 65535, 1, 0, 65535, 1, 512));
		pending_updates.push_back(make_update(0, 0, 65535, 1, 0, 65535, 1, 5));
		pending_updates.push_back(make_update(1, 1, 1000, 0, 500, 2000, 0, 10));
		// Full-size steps walk the blink phase across its flash bit.
		for (int i = 0; i < 5; i++)
			pending_updates.push_back(make_update(1, 1, 1000, 1, 500, 2000, 0, 256));
		pending_updates.push_back(make_update(1, 1, 700, 0, 500, 2000, 0, 1023));

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			case (seg)
				0: th = '0;
				1: th = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'h3FF};
				default: begin
					th.entry_low_margin = MARGIN_W'($urandom);
					th.entry_high_margin = MARGIN_W'($urandom);
					th.exit_low_margin = MARGIN_W'($urandom);
					th.exit_high_margin = MARGIN_W'($urandom);
					th.hold_time = TICK_W'($urandom);
				end
			endcase
			load_thresholds(th);
			send_gap_pct = (seg < 2) ? 36 : (seg < 4) ? 67 : 0;
			recv_stall_pct = (seg < 2) ? 67 : (seg < 4) ? 36 : 0;
			for (int n = 0; n < SEG_UPDATES; n++) begin
				// Halfway through, the sender holds off until every result is back.
				if (n == SEG_UPDATES / 2)
					wait_idle();
				pending_updates.push_back(random_update());
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS range_cue_qualifier");
		else
			$display("FAIL range_cue_qualifier");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/rcq_pkg.sv
hdl/rcq_step.sv
hdl/range_cue_qualifier.sv
sim/range_cue_qualifier_test.sv
